// ----- hw/rtl/rva_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rva_pkg
// Shared types and constants for the radial vignette alpha pipeline.
// ----------------------------------------------------------------------------
package rva_pkg;

  localparam int DIM_W      = 13;  // frame width / height register
  localparam int GAIN_W     = 16;  // distance gain, Q0.16
  localparam int EDGE_W     = 16;  // smoothstep edges, Q0.16
  localparam int EDGE_FRAC  = 16;  // fraction bits of gain and edges
  localparam int ALPHA_W    = 8;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_DISTANCE_GAIN = 3'd2,
    REG_INNER_EDGE   = 3'd3,
    REG_OUTER_EDGE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [GAIN_W-1:0] distance_gain;
    logic [EDGE_W-1:0] inner_edge;
    logic [EDGE_W-1:0] outer_edge;
  } cfg_t;

  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST   = 13'd320;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST  = 13'd180;
  localparam logic [GAIN_W-1:0] DISTANCE_GAIN_RST = 16'd39322;
  localparam logic [EDGE_W-1:0] INNER_EDGE_RST    = 16'd13107;
  localparam logic [EDGE_W-1:0] OUTER_EDGE_RST    = 16'd52429;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

endpackage
`default_nettype wire

// ----- hw/rtl/rva_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rva_regs
// APB configuration registers: frame size, distance gain and edges.
// ----------------------------------------------------------------------------
module rva_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rva_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rva_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rva_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output rva_pkg::cfg_t                   cfg
);
  import rva_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    unique case (idx)
      REG_FRAME_WIDTH: begin
        prdata = APB_DATA_W'(cfg_r.frame_width);
        if (wr_en) cfg_nxt.frame_width = pwdata[DIM_W-1:0];
      end
      REG_FRAME_HEIGHT: begin
        prdata = APB_DATA_W'(cfg_r.frame_height);
        if (wr_en) cfg_nxt.frame_height = pwdata[DIM_W-1:0];
      end
      REG_DISTANCE_GAIN: begin
        prdata = APB_DATA_W'(cfg_r.distance_gain);
        if (wr_en) cfg_nxt.distance_gain = pwdata[GAIN_W-1:0];
      end
      REG_INNER_EDGE: begin
        prdata = APB_DATA_W'(cfg_r.inner_edge);
        if (wr_en) cfg_nxt.inner_edge = pwdata[EDGE_W-1:0];
      end
      REG_OUTER_EDGE: begin
        prdata = APB_DATA_W'(cfg_r.outer_edge);
        if (wr_en) cfg_nxt.outer_edge = pwdata[EDGE_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= FRAME_WIDTH_RST;
      cfg_r.frame_height  <= FRAME_HEIGHT_RST;
      cfg_r.distance_gain <= DISTANCE_GAIN_RST;
      cfg_r.inner_edge    <= INNER_EDGE_RST;
      cfg_r.outer_edge    <= OUTER_EDGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rva_norm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rva_norm
// Coordinate normalizer: u = x * 2^F / width, v = y * 2^F / height, saturating
// at 1.0. Pipelined restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rva_norm #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [COORD_BITS-1:0]        pixel_x,
  input  logic [COORD_BITS-1:0]        pixel_y,
  input  logic [rva_pkg::DIM_W-1:0]    frame_width,
  input  logic [rva_pkg::DIM_W-1:0]    frame_height,
  output logic                         out_vld,
  output logic [FRAC_BITS:0]           u,
  output logic [FRAC_BITS:0]           v
);
  import rva_pkg::*;

  localparam int NST   = FRAC_BITS + 1;
  localparam int CMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

  logic [DIM_W-1:0]     wx, wy;
  logic [NST-1:0]       vld_r, vld_nxt;
  logic [NST-1:0]       satx_r, satx_nxt, saty_r, saty_nxt;
  logic [DIM_W-1:0]     rx_r [NST];
  logic [DIM_W-1:0]     rx_nxt [NST];
  logic [DIM_W-1:0]     ry_r [NST];
  logic [DIM_W-1:0]     ry_nxt [NST];
  logic [FRAC_BITS-1:0] qx_r [NST];
  logic [FRAC_BITS-1:0] qx_nxt [NST];
  logic [FRAC_BITS-1:0] qy_r [NST];
  logic [FRAC_BITS-1:0] qy_nxt [NST];

  // zero size behaves as one
  assign wx = (frame_width == '0) ? DIM_W'(1) : frame_width;
  assign wy = (frame_height == '0) ? DIM_W'(1) : frame_height;

  always_comb begin
    logic [DIM_W:0] tx, ty;
    logic           bx, by;
    // coordinate at or past the edge saturates; quotient then stays zero
    vld_nxt[0]  = in_vld;
    satx_nxt[0] = CMP_W'(pixel_x) >= CMP_W'(wx);
    saty_nxt[0] = CMP_W'(pixel_y) >= CMP_W'(wy);
    rx_nxt[0]   = satx_nxt[0] ? '0 : DIM_W'(pixel_x);
    ry_nxt[0]   = saty_nxt[0] ? '0 : DIM_W'(pixel_y);
    qx_nxt[0]   = '0;
    qy_nxt[0]   = '0;
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k]  = vld_r[k-1];
      satx_nxt[k] = satx_r[k-1];
      saty_nxt[k] = saty_r[k-1];
      tx = {rx_r[k-1], 1'b0};
      ty = {ry_r[k-1], 1'b0};
      bx = tx >= {1'b0, wx};
      by = ty >= {1'b0, wy};
      if (bx) tx = tx - {1'b0, wx};
      if (by) ty = ty - {1'b0, wy};
      rx_nxt[k] = tx[DIM_W-1:0];
      ry_nxt[k] = ty[DIM_W-1:0];
      qx_nxt[k] = {qx_r[k-1][FRAC_BITS-2:0], bx};
      qy_nxt[k] = {qy_r[k-1][FRAC_BITS-2:0], by};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      satx_r <= satx_nxt;
      saty_r <= saty_nxt;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
    end
  end

  assign out_vld = vld_r[NST-1];
  assign u       = {satx_r[NST-1], qx_r[NST-1]};
  assign v       = {saty_r[NST-1], qy_r[NST-1]};

endmodule
`default_nettype wire

// ----- hw/rtl/rva_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rva_isqrt
// Radial distance: offsets from the centre, squares, sum and a pipelined
// digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rva_isqrt #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [FRAC_BITS:0]   u,
  input  logic [FRAC_BITS:0]   v,
  output logic                 out_vld,
  output logic [FRAC_BITS-1:0] radius
);
  localparam int NSQ = FRAC_BITS + 1;      // sum stage plus one per root bit
  localparam int NST = NSQ + 2;            // abs and square stages in front
  localparam int SQ_W = 2 * FRAC_BITS;
  localparam logic [FRAC_BITS:0] HALF_Q = (FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);

  logic [NST-1:0]       vld_r, vld_nxt;
  logic [FRAC_BITS-1:0] adx_r, ady_r, adx_nxt, ady_nxt;
  logic [SQ_W-1:0]      sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic [SQ_W-1:0]      rad_r [NSQ];
  logic [SQ_W-1:0]      rad_nxt [NSQ];
  logic [FRAC_BITS+1:0] rem_r [NSQ];
  logic [FRAC_BITS+1:0] rem_nxt [NSQ];
  logic [FRAC_BITS-1:0] root_r [NSQ];
  logic [FRAC_BITS-1:0] root_nxt [NSQ];

  always_comb begin
    logic [FRAC_BITS+1:0] rm, trial;
    logic                 ge;
    vld_nxt = {vld_r[NST-2:0], in_vld};
    // |offset| <= 0.5, fits F bits
    adx_nxt = (u >= HALF_Q) ? FRAC_BITS'(u - HALF_Q) : FRAC_BITS'(HALF_Q - u);
    ady_nxt = (v >= HALF_Q) ? FRAC_BITS'(v - HALF_Q) : FRAC_BITS'(HALF_Q - v);
    sqx_nxt = SQ_W'(adx_r) * SQ_W'(adx_r);
    sqy_nxt = SQ_W'(ady_r) * SQ_W'(ady_r);
    rad_nxt[0]  = sqx_r + sqy_r;
    rem_nxt[0]  = '0;
    root_nxt[0] = '0;
    for (int k = 1; k < NSQ; k++) begin
      rm    = {rem_r[k-1][FRAC_BITS-1:0], rad_r[k-1][SQ_W-1 -: 2]};
      trial = {root_r[k-1], 2'b01};
      ge    = rm >= trial;
      rem_nxt[k]  = ge ? rm - trial : rm;
      root_nxt[k] = {root_r[k-1][FRAC_BITS-2:0], ge};
      rad_nxt[k]  = {rad_r[k-1][SQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx_r  <= adx_nxt;
      ady_r  <= ady_nxt;
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign out_vld = vld_r[NST-1];
  assign radius  = root_r[NSQ-1];

endmodule
`default_nettype wire

// ----- hw/rtl/rva_smooth.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rva_smooth
// Gain, smoothstep ratio (pipelined restoring division), 3s^2 - 2s^3 and the
// byte scale. Equal edges give a hard step.
// ----------------------------------------------------------------------------
module rva_smooth #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [FRAC_BITS-1:0]         radius,
  input  logic [rva_pkg::GAIN_W-1:0]   distance_gain,
  input  logic [rva_pkg::EDGE_W-1:0]   inner_edge,
  input  logic [rva_pkg::EDGE_W-1:0]   outer_edge,
  output logic                         out_vld,
  output logic [rva_pkg::ALPHA_W-1:0]  alpha
);
  import rva_pkg::*;

  // stage map: t | num | classify + F quotient bits | s^2 | w | alpha
  localparam int NDV = FRAC_BITS + 1;
  localparam int NST = FRAC_BITS + 6;
  localparam int PW  = FRAC_BITS + GAIN_W;
  localparam logic [FRAC_BITS:0]   ONE_Q   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS+1:0] THREE_Q = (FRAC_BITS + 2)'(3) << FRAC_BITS;

  logic [FRAC_BITS-1:0]          e1, e2, dabs;
  logic signed [FRAC_BITS:0]     den;
  logic                          den_neg, den_zero;

  logic [NST-1:0]                vld_r, vld_nxt;
  logic [NST-2:1]                hd_r, hd_nxt, hi_r, hi_nxt;
  logic [PW-1:0]                 tprod;
  logic [FRAC_BITS-1:0]          t_r, t_nxt;
  logic signed [FRAC_BITS:0]     num_r, num_nxt;
  logic [NDV-1:0]                fl_r, fl_nxt;
  logic [FRAC_BITS-1:0]          rem_r [NDV];
  logic [FRAC_BITS-1:0]          rem_nxt [NDV];
  logic [FRAC_BITS-1:0]          q_r [NDV];
  logic [FRAC_BITS-1:0]          q_nxt [NDV];
  logic [FRAC_BITS:0]            s;
  logic [2*FRAC_BITS+1:0]        sprod;
  logic [FRAC_BITS:0]            s2_r, s2_nxt;
  logic [FRAC_BITS+1:0]          tri_r, tri_nxt;
  logic [2*FRAC_BITS+2:0]        wprod;
  logic [FRAC_BITS:0]            w_r, w_nxt;
  logic [FRAC_BITS+ALPHA_W:0]    ascl;
  logic [ALPHA_W:0]              a9;
  logic [ALPHA_W-1:0]            alpha_r, alpha_nxt;

  if (FRAC_BITS >= EDGE_FRAC) begin : g_edge_up
    assign e1 = FRAC_BITS'(inner_edge) << (FRAC_BITS - EDGE_FRAC);
    assign e2 = FRAC_BITS'(outer_edge) << (FRAC_BITS - EDGE_FRAC);
  end else begin : g_edge_dn
    assign e1 = FRAC_BITS'(inner_edge >> (EDGE_FRAC - FRAC_BITS));
    assign e2 = FRAC_BITS'(outer_edge >> (EDGE_FRAC - FRAC_BITS));
  end

  // span depends on config only; reversed edges flip the sign of num instead
  assign den      = $signed({1'b0, e2}) - $signed({1'b0, e1});
  assign den_neg  = den < 0;
  assign den_zero = den == '0;
  assign dabs     = den_neg ? FRAC_BITS'(-den) : FRAC_BITS'(den);

  always_comb begin
    logic [FRAC_BITS:0] tw;
    logic               bq, zero, full;
    vld_nxt = {vld_r[NST-2:0], in_vld};

    tprod = PW'(radius) * PW'(distance_gain);
    t_nxt = tprod[PW-1:GAIN_W];

    num_nxt   = den_neg ? $signed({1'b0, e1}) - $signed({1'b0, t_r})
                        : $signed({1'b0, t_r}) - $signed({1'b0, e1});
    hd_nxt[1] = den_zero;
    hi_nxt[1] = t_r >= e1;
    for (int p = 2; p < NST - 1; p++) begin
      hd_nxt[p] = hd_r[p-1];
      hi_nxt[p] = hi_r[p-1];
    end

    // clamp ends skip the division: remainder zero keeps the quotient zero
    zero       = num_r <= 0;
    full       = num_r >= $signed({1'b0, dabs});
    fl_nxt[0]  = full;
    rem_nxt[0] = (zero || full) ? '0 : num_r[FRAC_BITS-1:0];
    q_nxt[0]   = '0;
    for (int k = 1; k < NDV; k++) begin
      tw = {rem_r[k-1], 1'b0};
      bq = tw >= {1'b0, dabs};
      if (bq) tw = tw - {1'b0, dabs};
      rem_nxt[k] = tw[FRAC_BITS-1:0];
      q_nxt[k]   = {q_r[k-1][FRAC_BITS-2:0], bq};
      fl_nxt[k]  = fl_r[k-1];
    end

    s       = fl_r[NDV-1] ? ONE_Q : {1'b0, q_r[NDV-1]};
    sprod   = (2*FRAC_BITS+2)'(s) * (2*FRAC_BITS+2)'(s);
    s2_nxt  = sprod[2*FRAC_BITS:FRAC_BITS];
    tri_nxt = THREE_Q - {s, 1'b0};

    // w <= 1.0 so the upper product bits are zero
    wprod = (2*FRAC_BITS+3)'(s2_r) * (2*FRAC_BITS+3)'(tri_r);
    w_nxt = wprod[2*FRAC_BITS:FRAC_BITS];

    // w * 255 as shift and subtract
    ascl = {w_r, {ALPHA_W{1'b0}}} - (FRAC_BITS + ALPHA_W + 1)'(w_r);
    a9   = ascl[FRAC_BITS+ALPHA_W:FRAC_BITS];
    if (hd_r[NST-2]) begin
      alpha_nxt = hi_r[NST-2] ? ALPHA_MAX : '0;
    end else if (a9 > (ALPHA_W + 1)'(ALPHA_MAX)) begin
      alpha_nxt = ALPHA_MAX;
    end else begin
      alpha_nxt = a9[ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= t_nxt;
      num_r   <= num_nxt;
      hd_r    <= hd_nxt;
      hi_r    <= hi_nxt;
      fl_r    <= fl_nxt;
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
      s2_r    <= s2_nxt;
      tri_r   <= tri_nxt;
      w_r     <= w_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_vld = vld_r[NST-1];
  assign alpha   = alpha_r;

endmodule
`default_nettype wire

// ----- hw/rtl/radial_vignette_alpha.sv -----
`default_nettype none
// Pipe order: normalizer, distance and root pipe, smoothstep pipe, output register.
// Throughput: one pixel per cycle unless stalled; bit-per-stage divider and root pipes.
// A two-entry output stage (output register plus skid) holds results under out_stall;
// in_stall rises only when both are full.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// radial_vignette_alpha
// Radial vignette opacity per pixel: normalize, distance, gain, smoothstep,
// scale to a byte.
// ----------------------------------------------------------------------------
module radial_vignette_alpha #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [COORD_BITS-1:0]          in_pixel_x,
  input  logic [COORD_BITS-1:0]          in_pixel_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rva_pkg::ALPHA_W-1:0]    out_alpha,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rva_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rva_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rva_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rva_pkg::*;

  cfg_t                 cfg;
  logic                 en;
  logic                 nrm_vld, dst_vld, pipe_vld;
  logic [FRAC_BITS:0]   u, v;
  logic [FRAC_BITS-1:0] radius;
  logic [ALPHA_W-1:0]   pipe_alpha;
  logic                 out_free;
  logic                 out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  logic [ALPHA_W-1:0]   out_alpha_r, out_alpha_nxt, skid_alpha_r, skid_alpha_nxt;

  rva_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rva_norm #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_norm (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_vld       (in_valid),
    .pixel_x      (in_pixel_x),
    .pixel_y      (in_pixel_y),
    .frame_width  (cfg.frame_width),
    .frame_height (cfg.frame_height),
    .out_vld      (nrm_vld),
    .u            (u),
    .v            (v)
  );

  rva_isqrt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (nrm_vld),
    .u       (u),
    .v       (v),
    .out_vld (dst_vld),
    .radius  (radius)
  );

  rva_smooth #(
    .FRAC_BITS (FRAC_BITS)
  ) u_smooth (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_vld        (dst_vld),
    .radius        (radius),
    .distance_gain (cfg.distance_gain),
    .inner_edge    (cfg.inner_edge),
    .outer_edge    (cfg.outer_edge),
    .out_vld       (pipe_vld),
    .alpha         (pipe_alpha)
  );

  // pipeline moves whenever the skid entry is free
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;
  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    out_vld_nxt    = out_vld_r;
    out_alpha_nxt  = out_alpha_r;
    skid_vld_nxt   = skid_vld_r;
    skid_alpha_nxt = skid_alpha_r;
    if (skid_vld_r) begin
      if (out_free) begin
        out_vld_nxt   = 1'b1;
        out_alpha_nxt = skid_alpha_r;
        skid_vld_nxt  = 1'b0;
      end
    end else if (out_free) begin
      out_vld_nxt   = pipe_vld;
      out_alpha_nxt = pipe_alpha;
    end else if (pipe_vld) begin
      // output held: park the item leaving the last stage
      skid_vld_nxt   = 1'b1;
      skid_alpha_nxt = pipe_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_alpha_r  <= out_alpha_nxt;
    skid_alpha_r <= skid_alpha_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_alpha = out_alpha_r;

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for radial_vignette_alpha. Every accepted pixel gets its
// alpha byte predicted from a local copy of the registers, and results are
// checked in order. It covers the register extremes and random frames, with
// random idle cycles on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import rva_pkg::*;

  localparam int     COORD_W      = 12;
  localparam int     FRAC_BITS    = 16;
  localparam int     PIPE_LATENCY = 3 * FRAC_BITS + 10;
  localparam longint ONE_Q        = 64'sd1 << FRAC_BITS;
  localparam longint HALF_Q       = 64'sd1 << (FRAC_BITS - 1);
  localparam longint TIMEOUT_NS   = 5_000_000;

  // register indexes with nothing behind them
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_W-1:0]    in_pixel_x;
  logic [COORD_W-1:0]    in_pixel_y;
  logic                  out_valid;
  logic                  out_stall;
  logic [ALPHA_W-1:0]    out_alpha;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cfg_t               shadow_cfg;
  logic [ALPHA_W-1:0] pending_alpha[$];
  int                 mismatches = 0;
  bit                 src_gaps   = 1'b0;
  bit                 sink_gaps  = 1'b0;
  int                 hold_off_cycles = 0;

  radial_vignette_alpha #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_alpha (out_alpha),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint norm_coord(input logic [COORD_W-1:0] c,
                                        input logic [DIM_W-1:0] size);
    longint q;
    q = (longint'(c) << FRAC_BITS) / ((size == '0) ? 64'sd1 : longint'(size));
    if (q > ONE_Q) q = ONE_Q;
    return q;
  endfunction

  function automatic longint int_sqrt(input longint n);
    longint root;
    longint trial;
    root = 0;
    // radicand stays below 2^32, so the root fits in 17 bits
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'sd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [ALPHA_W-1:0] vignette_alpha(input logic [COORD_W-1:0] px,
                                                        input logic [COORD_W-1:0] py,
                                                        input cfg_t c);
    longint dx, dy, radius, t, lo, hi, num, den, s, s2, w, a;
    dx     = norm_coord(px, c.frame_width) - HALF_Q;
    dy     = norm_coord(py, c.frame_height) - HALF_Q;
    radius = int_sqrt(dx * dx + dy * dy);
    t      = (radius * longint'(c.distance_gain)) >>> EDGE_FRAC;
    lo     = longint'(c.inner_edge) << (FRAC_BITS - EDGE_FRAC);
    hi     = longint'(c.outer_edge) << (FRAC_BITS - EDGE_FRAC);
    if (hi == lo) return (t < lo) ? '0 : ALPHA_MAX;
    num = t - lo;
    den = hi - lo;
    // reversed edges: same ratio on the mirrored span
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) s = 0;
    else if (num >= den) s = ONE_Q;
    else s = (num << FRAC_BITS) / den;
    s2 = (s * s) >>> FRAC_BITS;
    w  = (s2 * (3 * ONE_Q - 2 * s)) >>> FRAC_BITS;
    a  = (w * 255) >>> FRAC_BITS;
    if (a > 255) a = 255;
    return a[ALPHA_W-1:0];
  endfunction

  // ------------------------------------------------------ transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_alpha.push_back(vignette_alpha(in_pixel_x, in_pixel_y, shadow_cfg));
  end

  always @(posedge clk) begin : check_alpha
    logic [ALPHA_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_alpha.size() == 0) begin
        $error("alpha: unexpected transfer, actual %0d", out_alpha);
        mismatches++;
      end else begin
        want = pending_alpha.pop_front();
        if (out_alpha !== want) begin
          $error("alpha: expected %0d, actual %0d", want, out_alpha);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold-off
  initial begin : sink_stall
    int left;
    left      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        left            = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        left = $urandom_range(0, 8);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // ------------------------------------------------------------------ tasks
  task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait until every expected alpha has come back
  task automatic quiesce(input int tail);
    in_valid <= 1'b0;
    while (pending_alpha.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   shadow_cfg.frame_width   = value[DIM_W-1:0];
      REG_FRAME_HEIGHT:  shadow_cfg.frame_height  = value[DIM_W-1:0];
      REG_DISTANCE_GAIN: shadow_cfg.distance_gain = value[GAIN_W-1:0];
      REG_INNER_EDGE:    shadow_cfg.inner_edge    = value[EDGE_W-1:0];
      REG_OUTER_EDGE:    shadow_cfg.outer_edge    = value[EDGE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_cfg(input int w, input int h, input int gain, input int e_in,
                          input int e_out);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_DISTANCE_GAIN, gain);
    write_reg(REG_INNER_EDGE, e_in);
    write_reg(REG_OUTER_EDGE, e_out);
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(1, 16);
      1:       return $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  // mostly inside the frame, some anywhere in the coordinate range
  function automatic logic [COORD_W-1:0] pick_coord(input logic [DIM_W-1:0] size);
    int unsigned lim;
    if ($urandom_range(0, 9) == 0) return COORD_W'($urandom);
    lim = (size == '0) ? 1 : ((size > 4096) ? 4096 : size);
    return COORD_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic randomize_cfg();
    logic [31:0] junk;
    int          gain, e_in, e_out;
    junk  = $urandom_range(0, 1) ? $urandom : 32'd0;
    gain  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                        : $urandom_range(16384, 65535);
    case ($urandom_range(0, 9))
      0: begin
        e_in  = $urandom_range(0, 40000);
        e_out = e_in;
      end
      1, 2: begin
        e_in  = $urandom_range(0, 65535);
        e_out = $urandom_range(0, 65535);
      end
      default: begin
        e_in  = $urandom_range(0, 32767);
        e_out = e_in + $urandom_range(1, 65535 - e_in);
      end
    endcase
    // upper data bits carry junk that the block must drop
    write_reg(REG_FRAME_WIDTH, {junk[31:DIM_W], DIM_W'(pick_dim())});
    write_reg(REG_FRAME_HEIGHT, {junk[31:DIM_W], DIM_W'(pick_dim())});
    write_reg(REG_DISTANCE_GAIN, {junk[31:GAIN_W], GAIN_W'(gain)});
    write_reg(REG_INNER_EDGE, {junk[31:EDGE_W], EDGE_W'(e_in)});
    write_reg(REG_OUTER_EDGE, {junk[31:EDGE_W], EDGE_W'(e_out)});
  endtask

  // ------------------------------------------------------------------ tests
  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd160, 12'd90);
    send_pixel(12'd319, 12'd179);
    send_pixel(12'd0, 12'd179);
    send_pixel(12'd319, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);   // past the frame, saturates
    quiesce(4);
  endtask

  task automatic test_register_corners();
    // zero frame size acts as one; full gain, full edge span
    load_cfg(32'hFFFF_E000, 32'hA5A5_4000, 65535, 0, 65535);
    write_reg(REG_UNMAPPED_LO, 32'h0000_0001);
    write_reg(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'hFFF, 12'd0);
    quiesce(4);
    // hard step at a mid edge, largest power-of-two frame
    load_cfg(4096, 4096, 65535, 20000, 20000);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'd2048);
    send_pixel(12'd2048, 12'd1000);
    quiesce(4);
    // reversed edges: alpha falls with distance
    load_cfg(320, 180, 39322, 52429, 13107);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd160, 12'd90);
    send_pixel(12'd80, 12'd45);
    quiesce(4);
    // widest frame register, zero gain, both edges at zero
    load_cfg(8191, 1, 0, 0, 0);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    quiesce(4);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 9; phase++) begin
      randomize_cfg();
      src_gaps  = (phase % 3) != 2;
      sink_gaps = (phase % 4) != 3;
      for (int i = 0; i < 95; i++)
        send_pixel(pick_coord(shadow_cfg.frame_width), pick_coord(shadow_cfg.frame_height));
      quiesce(4);
    end
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
  endtask

  // receiver holds off long enough for the pipe to fill and stall the sender
  task automatic test_output_backpressure();
    load_cfg(640, 480, 52000, 8000, 40000);
    hold_off_cycles = 4 * PIPE_LATENCY + 150;
    for (int i = 0; i < 100; i++)
      send_pixel(pick_coord(shadow_cfg.frame_width), pick_coord(shadow_cfg.frame_height));
    quiesce(4);
  endtask

  task automatic test_steady_stream();
    randomize_cfg();
    for (int i = 0; i < 60; i++)
      send_pixel(pick_coord(shadow_cfg.frame_width), pick_coord(shadow_cfg.frame_height));
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    shadow_cfg = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, DISTANCE_GAIN_RST,
                   INNER_EDGE_RST, OUTER_EDGE_RST};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_corners();
    test_random_traffic();
    test_output_backpressure();
    test_steady_stream();
    quiesce(PIPE_LATENCY + 10);

    if (mismatches == 0 && pending_alpha.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
